>>> rtl/soft_bounded_sigmoid_weight_update_macros.svh
// Assertion macros shared by the weight update RTL.
`ifndef SOFT_BOUNDED_SIGMOID_WEIGHT_UPDATE_MACROS_SVH
`define SOFT_BOUNDED_SIGMOID_WEIGHT_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define SBSW_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define SBSW_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sbsw_pkg.sv
// Shared types and constants for the soft-bounded sigmoid weight update.
`default_nettype none
package sbsw_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DW_W      = 18;
    localparam int LW_W      = 17;
    localparam int EW_W      = 20;
    localparam int GW_W      = 18;
    localparam int SC_W      = 20;
    localparam int Q_W       = 31;
    localparam int DIV_STEP  = 4;

    localparam logic [LW_W-1:0] ONE_FX = 17'd1 << FRAC_BITS;
    localparam logic [Q_W-1:0]  Q_ONE  = 31'd1 << 30;

    typedef enum logic [0:0] {
        CFG_SOFT_BOUND    = 1'b0,
        CFG_CONTRAST_MODE = 1'b1
    } cfg_idx_t;

    // Per-word information that rides alongside the arithmetic.
    typedef struct packed {
        logic            zero;
        logic            ge;
        logic [LW_W-1:0] lwt_new;
        logic [LW_W-1:0] lwt_raw;
        logic [EW_W-1:0] wt;
        logic [SC_W-1:0] scale;
    } side_t;
endpackage
`default_nettype wire

>>> rtl/soft_bounded_sigmoid_weight_update.sv
// Top level of the soft-bounded sigmoid weight update pipeline.
//
//   Channel   Handshake            Words
//   s_        s_valid / s_ready    change, weights, gains, scale in
//   m_        m_valid / m_ready    new linear and effective weight, updated flag
//   cfg_      cfg_we               soft_bound, contrast_mode
//
// One word enters per cycle while the output is not stalled; the stages are four
// front stages, two operand stages, eight ratio divider stages, five power
// stages, five final divider stages, the scale multiply and the output register.
// Synchronous active-low reset clears valid bits and sets both config bits.
// A stall at the output freezes the whole pipeline; s_ready = !m_valid | m_ready.
`default_nettype none
`include "soft_bounded_sigmoid_weight_update_macros.svh"
module soft_bounded_sigmoid_weight_update import sbsw_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [0:0]             cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [DW_W-1:0] s_delta_weight,
    input  logic [LW_W-1:0]        s_linear_weight,
    input  logic [EW_W-1:0]        s_effective_weight,
    input  logic [GW_W-1:0]        s_increase_gain,
    input  logic [GW_W-1:0]        s_decrease_gain,
    input  logic [SC_W-1:0]        s_weight_scale,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LW_W-1:0]        m_new_linear_weight,
    output logic [EW_W-1:0]        m_new_effective_weight,
    output logic                   m_updated
);
    localparam int SIDE_W = $bits(side_t);

    logic soft_bound_reg, contrast_mode_reg;
    logic pipe_en;

    logic  f_valid;
    side_t f_side;

    logic            p1_valid_reg;
    logic [16:0]     p1_rem_reg;
    logic [Q_W-1:0]  p1_dlow_reg;
    logic [16:0]     p1_dvs_reg;
    side_t           p1_side_reg;
    side_t           p1_side_next;
    logic [LW_W-1:0] a_w, b_w;

    logic              d1_valid;
    logic [Q_W-1:0]    d1_q;
    logic [SIDE_W-1:0] d1_side_vec;
    side_t             d1_side;

    logic           pw_valid;
    logic [Q_W-1:0] pw_p;
    side_t          pw_side;

    logic        p2_valid_reg;
    logic [31:0] p2_rem_reg;
    logic [16:0] p2_dlow_reg;
    logic [31:0] p2_dvs_reg;
    side_t       p2_side_reg;

    logic              d2_valid;
    logic [16:0]       d2_q;
    logic [SIDE_W-1:0] d2_side_vec;
    side_t             d2_side;

    logic [LW_W-1:0] sig;
    logic            mul_valid_reg;
    logic [36:0]     mprod_reg;
    side_t           mside_reg;
    logic [20:0]     eff_wide;
    logic [EW_W-1:0] eff_sat;

    logic            m_valid_reg;
    logic [LW_W-1:0] m_lwt_reg;
    logic [EW_W-1:0] m_eff_reg;
    logic            m_upd_reg;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soft_bound_reg    <= 1'b1;
            contrast_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SOFT_BOUND:    soft_bound_reg    <= cfg_wdata[0];
                CFG_CONTRAST_MODE: contrast_mode_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // The whole pipeline moves whenever the output word can advance.
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    sbsw_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (pipe_en),
        .in_valid         (s_valid),
        .delta_weight     (s_delta_weight),
        .linear_weight    (s_linear_weight),
        .effective_weight (s_effective_weight),
        .increase_gain    (s_increase_gain),
        .decrease_gain    (s_decrease_gain),
        .weight_scale     (s_weight_scale),
        .soft_bound       (soft_bound_reg),
        .out_valid        (f_valid),
        .out_side         (f_side)
    );

    // Ratio operands: smaller over larger of w and one minus w, in Q30.
    assign a_w = f_side.lwt_new;
    assign b_w = ONE_FX - f_side.lwt_new;

    // The side word records which of the two operands is the larger.
    always_comb begin
        p1_side_next    = f_side;
        p1_side_next.ge = (a_w >= b_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_valid_reg <= f_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_side_reg <= p1_side_next;
            if (a_w < b_w) begin
                p1_rem_reg  <= {1'b0, a_w[16:1]};
                p1_dlow_reg <= {a_w[0], 30'b0};
                p1_dvs_reg  <= b_w;
            end else begin
                p1_rem_reg  <= {1'b0, b_w[16:1]};
                p1_dlow_reg <= {b_w[0], 30'b0};
                p1_dvs_reg  <= a_w;
            end
        end
    end

    sbsw_div #(
        .DVS_W  (17),
        .QUO_W  (Q_W),
        .STEP_N (DIV_STEP),
        .SIDE_W (SIDE_W)
    ) u_div_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (p1_valid_reg),
        .rem_i     (p1_rem_reg),
        .dlow_i    (p1_dlow_reg),
        .dvs_i     (p1_dvs_reg),
        .side_i    (p1_side_reg),
        .out_valid (d1_valid),
        .quo_o     (d1_q),
        .side_o    (d1_side_vec)
    );
    assign d1_side = d1_side_vec;

    sbsw_power u_power (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (d1_valid),
        .q_i       (d1_q),
        .side_i    (d1_side),
        .out_valid (pw_valid),
        .p_o       (pw_p),
        .side_o    (pw_side)
    );

    // Final division operands: one or p over one plus p, scaled to 16 bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p2_valid_reg <= pw_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p2_side_reg <= pw_side;
            p2_dvs_reg  <= {1'b0, pw_p} + {1'b0, Q_ONE};
            if (pw_side.ge) begin
                p2_rem_reg  <= 32'h2000_0000;
                p2_dlow_reg <= '0;
            end else begin
                p2_rem_reg  <= {2'b00, pw_p[30:1]};
                p2_dlow_reg <= {pw_p[0], 16'b0};
            end
        end
    end

    sbsw_div #(
        .DVS_W  (32),
        .QUO_W  (17),
        .STEP_N (DIV_STEP),
        .SIDE_W (SIDE_W)
    ) u_div_sig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (p2_valid_reg),
        .rem_i     (p2_rem_reg),
        .dlow_i    (p2_dlow_reg),
        .dvs_i     (p2_dvs_reg),
        .side_i    (p2_side_reg),
        .out_valid (d2_valid),
        .quo_o     (d2_q),
        .side_o    (d2_side_vec)
    );
    assign d2_side = d2_side_vec;

    // Scale multiply of the sigmoid or of the plain linear weight.
    assign sig = contrast_mode_reg ? d2_q : d2_side.lwt_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            mul_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mprod_reg <= 37'(d2_side.scale) * 37'(sig);
            mside_reg <= d2_side;
        end
    end

    // Saturate and pick the pass-through word for a zero change.
    assign eff_wide = mprod_reg[36:16];
    assign eff_sat  = eff_wide[20] ? '1 : eff_wide[19:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_lwt_reg <= mside_reg.zero ? mside_reg.lwt_raw : mside_reg.lwt_new;
            m_eff_reg <= mside_reg.zero ? mside_reg.wt : eff_sat;
            m_upd_reg <= !mside_reg.zero;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_new_linear_weight    = m_lwt_reg;
    assign m_new_effective_weight = m_eff_reg;
    assign m_updated              = m_upd_reg;

    `SBSW_CHECK(a_lwt_max, m_valid && m_updated, m_new_linear_weight <= ONE_FX, "linear weight above one")
    `SBSW_CHECK(a_sig_max, d2_valid, d2_q <= 17'(ONE_FX), "sigmoid above one")
    `SBSW_CHECK(a_stall_block, m_valid && !m_ready, !s_ready, "word taken during stall")
    `SBSW_CHECK_NEXT(a_hold_prod, !pipe_en, $stable(mprod_reg), "product moved during stall")
endmodule
`default_nettype wire

>>> rtl/sbsw_front.sv
// Front pipeline: gain-scaled step, soft-bounded when enabled, and clipped linear weight update.
`default_nettype none
module sbsw_front import sbsw_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [DW_W-1:0] delta_weight,
    input  logic [LW_W-1:0]        linear_weight,
    input  logic [EW_W-1:0]        effective_weight,
    input  logic [GW_W-1:0]        increase_gain,
    input  logic [GW_W-1:0]        decrease_gain,
    input  logic [SC_W-1:0]        weight_scale,
    input  logic                   soft_bound,
    output logic                   out_valid,
    output side_t                  out_side
);
    logic [DW_W-1:0] du;
    logic            neg;
    logic [DW_W-1:0] mag;
    logic [GW_W-1:0] gain;
    logic [LW_W-1:0] lwt_sat;
    logic [LW_W-1:0] bound;
    side_t           sd0;

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic            neg1_reg, neg2_reg, neg3_reg;
    logic [35:0]     p1_reg;
    logic [LW_W-1:0] bound1_reg;
    logic [34:0]     pl2_reg, ph2_reg;
    logic [18:0]     ns2_reg;
    logic [18:0]     step3_reg;
    logic [52:0]     full3;
    side_t           sd1_reg, sd2_reg, sd3_reg, sd4_reg;
    side_t           sd4_next;
    logic [LW_W-1:0] lwt4_next;
    logic [19:0]     sum4;

    // Decode the incoming word: sign, magnitude, gain and bound.
    always_comb begin
        du      = delta_weight;
        neg     = du[DW_W-1];
        mag     = neg ? (~du + 18'd1) : du;
        gain    = neg ? decrease_gain : increase_gain;
        lwt_sat = (linear_weight > ONE_FX) ? ONE_FX : linear_weight;
        bound   = neg ? lwt_sat : (ONE_FX - lwt_sat);
        sd0.zero    = (du == '0);
        sd0.ge      = 1'b0;
        sd0.lwt_new = lwt_sat;
        sd0.lwt_raw = linear_weight;
        sd0.wt      = effective_weight;
        sd0.scale   = weight_scale;
    end

    // Valid bits advance with the pipeline enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Combine the two partial products of the soft-bounded step.
    assign full3 = {ph2_reg, 18'b0} + 53'(pl2_reg);

    // Add or subtract the step and clip to the unit range.
    always_comb begin
        sum4 = 20'(sd3_reg.lwt_new) + 20'(step3_reg);
        if (neg3_reg) begin
            if (step3_reg >= 19'(sd3_reg.lwt_new)) begin
                lwt4_next = '0;
            end else begin
                lwt4_next = 17'(19'(sd3_reg.lwt_new) - step3_reg);
            end
        end else begin
            lwt4_next = (sum4 > 20'(ONE_FX)) ? ONE_FX : sum4[LW_W-1:0];
        end
    end

    // The side word of the last stage carries the new linear weight.
    always_comb begin
        sd4_next         = sd3_reg;
        sd4_next.lwt_new = lwt4_next;
    end

    // Datapath registers: gain product, bound products, step, new weight.
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg     <= mag * gain;
            bound1_reg <= bound;
            neg1_reg   <= neg;
            sd1_reg    <= sd0;

            pl2_reg  <= p1_reg[17:0] * bound1_reg;
            ph2_reg  <= p1_reg[35:18] * bound1_reg;
            ns2_reg  <= p1_reg[34:16];
            neg2_reg <= neg1_reg;
            sd2_reg  <= sd1_reg;

            step3_reg <= soft_bound ? full3[50:32] : ns2_reg;
            neg3_reg  <= neg2_reg;
            sd3_reg   <= sd2_reg;

            sd4_reg <= sd4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = sd4_reg;
endmodule
`default_nettype wire

>>> rtl/sbsw_div.sv
// Pipelined restoring divider, STEP_N quotient bits per stage (fewer in the last stage).
`default_nettype none
module sbsw_div import sbsw_pkg::*; #(
    parameter int DVS_W  = 17,
    parameter int QUO_W  = 31,
    parameter int STEP_N = 4,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVS_W-1:0]  rem_i,
    input  logic [QUO_W-1:0]  dlow_i,
    input  logic [DVS_W-1:0]  dvs_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo_o,
    output logic [SIDE_W-1:0] side_o
);
    localparam int NSTG = (QUO_W + STEP_N - 1) / STEP_N;

    logic              vld_reg  [NSTG];
    logic [DVS_W-1:0]  rem_reg  [NSTG];
    logic [QUO_W-1:0]  dlow_reg [NSTG];
    logic [QUO_W-1:0]  quo_reg  [NSTG];
    logic [DVS_W-1:0]  dvs_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];

    logic              vld_in  [NSTG];
    logic [DVS_W-1:0]  rem_in  [NSTG];
    logic [QUO_W-1:0]  dlow_in [NSTG];
    logic [QUO_W-1:0]  quo_in  [NSTG];
    logic [DVS_W-1:0]  dvs_in  [NSTG];
    logic [SIDE_W-1:0] side_in [NSTG];

    // Stage inputs come from the ports or the previous stage.
    assign vld_in[0]  = in_valid;
    assign rem_in[0]  = rem_i;
    assign dlow_in[0] = dlow_i;
    assign quo_in[0]  = '0;
    assign dvs_in[0]  = dvs_i;
    assign side_in[0] = side_i;

    for (genvar s = 1; s < NSTG; s++) begin : g_link
        assign vld_in[s]  = vld_reg[s-1];
        assign rem_in[s]  = rem_reg[s-1];
        assign dlow_in[s] = dlow_reg[s-1];
        assign quo_in[s]  = quo_reg[s-1];
        assign dvs_in[s]  = dvs_reg[s-1];
        assign side_in[s] = side_reg[s-1];
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        localparam int LEFT = QUO_W - s * STEP_N;
        localparam int NS   = (LEFT < STEP_N) ? LEFT : STEP_N;

        logic [DVS_W:0]   t;
        logic [DVS_W-1:0] rem_c;
        logic [QUO_W-1:0] dl_c;
        logic [QUO_W-1:0] q_c;

        // Shift in one dividend bit per step and subtract when it fits.
        always_comb begin
            rem_c = rem_in[s];
            dl_c  = dlow_in[s];
            q_c   = quo_in[s];
            t     = '0;
            for (int k = 0; k < NS; k++) begin
                t    = {rem_c, dl_c[QUO_W-1]};
                dl_c = dl_c << 1;
                if (t >= {1'b0, dvs_in[s]}) begin
                    t   = t - {1'b0, dvs_in[s]};
                    q_c = {q_c[QUO_W-2:0], 1'b1};
                end else begin
                    q_c = {q_c[QUO_W-2:0], 1'b0};
                end
                rem_c = t[DVS_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_c;
                dlow_reg[s] <= dl_c;
                quo_reg[s]  <= q_c;
                dvs_reg[s]  <= dvs_in[s];
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign quo_o     = quo_reg[NSTG-1];
    assign side_o    = side_reg[NSTG-1];
endmodule
`default_nettype wire

>>> rtl/sbsw_power.sv
// Sixth power of the Q30 ratio by five registered truncating multiplies.
`default_nettype none
module sbsw_power import sbsw_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [Q_W-1:0] q_i,
    input  side_t          side_i,
    output logic           out_valid,
    output logic [Q_W-1:0] p_o,
    output side_t          side_o
);
    localparam int NMUL = 5;

    logic           vld_reg  [NMUL];
    logic [Q_W-1:0] p_reg    [NMUL];
    logic [Q_W-1:0] q_reg    [NMUL];
    side_t          side_reg [NMUL];

    logic           vld_in  [NMUL];
    logic [Q_W-1:0] p_in    [NMUL];
    logic [Q_W-1:0] q_in    [NMUL];
    side_t          side_in [NMUL];

    assign vld_in[0]  = in_valid;
    assign p_in[0]    = q_i;
    assign q_in[0]    = q_i;
    assign side_in[0] = side_i;

    for (genvar s = 1; s < NMUL; s++) begin : g_link
        assign vld_in[s]  = vld_reg[s-1];
        assign p_in[s]    = p_reg[s-1];
        assign q_in[s]    = q_reg[s-1];
        assign side_in[s] = side_reg[s-1];
    end

    for (genvar s = 0; s < NMUL; s++) begin : g_mul
        logic [2*Q_W-1:0] prod;

        // One Q30 multiply per stage, truncated back to Q30.
        assign prod = p_in[s] * q_in[s];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[s]    <= prod[60:30];
                q_reg[s]    <= q_in[s];
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign out_valid = vld_reg[NMUL-1];
    assign p_o       = p_reg[NMUL-1];
    assign side_o    = side_reg[NMUL-1];
endmodule
`default_nettype wire

>>> tb/sv/tb_soft_bounded_sigmoid_weight_update.sv
// Self-checking testbench for the soft-bounded sigmoid weight update pipeline.
`default_nettype none
module tb_soft_bounded_sigmoid_weight_update;
    import sbsw_pkg::*;

    localparam int LATENCY   = 26;
    localparam int WDOG_MAX  = 4000;
    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic [63:0] Q1_64 = 64'd1 << 30;

    // One input word and one result word.
    typedef struct packed {
        logic signed [DW_W-1:0] dw;
        logic [LW_W-1:0]        lw;
        logic [EW_W-1:0]        ew;
        logic [GW_W-1:0]        ginc;
        logic [GW_W-1:0]        gdec;
        logic [SC_W-1:0]        scale;
    } syn_in_t;

    typedef struct packed {
        logic [LW_W-1:0] nlw;
        logic [EW_W-1:0] new_;
        logic            upd;
    } syn_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = 1'b0;
    logic [0:0] cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [DW_W-1:0] s_delta_weight = '0;
    logic [LW_W-1:0] s_linear_weight = '0;
    logic [EW_W-1:0] s_effective_weight = '0;
    logic [GW_W-1:0] s_increase_gain = '0;
    logic [GW_W-1:0] s_decrease_gain = '0;
    logic [SC_W-1:0] s_weight_scale = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [LW_W-1:0] m_new_linear_weight;
    logic [EW_W-1:0] m_new_effective_weight;
    logic m_updated;

    // Predictor copy of the configuration bits.
    logic bound_en = 1'b1;
    logic sigmoid_en = 1'b1;

    syn_out_t expected_weights[$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int idle_cycles = 0;
    int stall_mode = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    soft_bounded_sigmoid_weight_update u_top (.*);

    // Sixth-power sigmoid contrast in Q30 with truncating multiplies.
    function automatic logic [63:0] sigmoid_contrast(input logic [63:0] w);
        logic [63:0] lo, hi, q, p, den;
        if (w == 0) return 0;
        if (w >= ONE64) return ONE64;
        lo = (w < ONE64 - w) ? w : ONE64 - w;
        hi = (w < ONE64 - w) ? ONE64 - w : w;
        q = (lo << 30) / hi;
        p = q;
        for (int i = 1; i < 6; i++) p = (p * q) >> 30;
        den = Q1_64 + p;
        if (w >= ONE64 - w) return (ONE64 << 30) / den;
        return (p * ONE64) / den;
    endfunction

    // Expected weights for one synapse under the current configuration.
    function automatic syn_out_t predict_weights(input syn_in_t it);
        syn_out_t r;
        logic [63:0] lw, mag, stp, gain, c, eff;
        logic neg;
        if (it.dw == 0) begin
            r.nlw = it.lw;
            r.new_ = it.ew;
            r.upd = 1'b0;
            return r;
        end
        neg = it.dw[DW_W-1];
        lw = (it.lw > ONE64) ? ONE64 : 64'(it.lw);
        mag = neg ? (64'd1 << DW_W) - 64'(unsigned'(it.dw)) : 64'(unsigned'(it.dw));
        gain = neg ? 64'(it.gdec) : 64'(it.ginc);
        if (bound_en)
            stp = (mag * gain * (neg ? lw : ONE64 - lw)) >> (2 * FRAC_BITS);
        else
            stp = (mag * gain) >> FRAC_BITS;
        if (neg) lw = (stp >= lw) ? 0 : lw - stp;
        else lw = (lw + stp > ONE64) ? ONE64 : lw + stp;
        c = sigmoid_en ? sigmoid_contrast(lw) : lw;
        eff = (64'(it.scale) * c) >> FRAC_BITS;
        if (eff > 64'hFFFFF) eff = 64'hFFFFF;
        r.nlw = lw[LW_W-1:0];
        r.new_ = eff[EW_W-1:0];
        r.upd = 1'b1;
        return r;
    endfunction

    // Send one word; valid stays up across back-to-back words.
    task automatic send_word(input syn_in_t it, input bit hold_valid);
        s_valid <= 1'b1;
        s_delta_weight <= it.dw;
        s_linear_weight <= it.lw;
        s_effective_weight <= it.ew;
        s_increase_gain <= it.ginc;
        s_decrease_gain <= it.gdec;
        s_weight_scale <= it.scale;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_weights.push_back(predict_weights(it));
        words_sent++;
        if (!hold_valid) s_valid <= 1'b0;
    endtask

    // Bursts of random length with random gaps between them.
    task automatic send_burst(input syn_in_t items[$]);
        int left;
        left = 0;
        foreach (items[i]) begin
            if (left == 0) begin
                left = $urandom_range(1, 12);
                if ($urandom_range(0, 2) == 0 && i > 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                end
            end
            left--;
            send_word(items[i], i != items.size() - 1);
        end
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_weights.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SOFT_BOUND) bound_en = val;
        else sigmoid_en = val;
    endtask

    function automatic syn_in_t random_word();
        syn_in_t it;
        int sel;
        sel = $urandom_range(0, 9);
        it.dw = DW_W'($urandom);
        if (sel == 0) it.dw = '0;
        else if (sel == 1) it.dw = DW_W'($urandom_range(0, 64)) - DW_W'(32);
        it.lw = ($urandom_range(0, 15) == 0) ? LW_W'($urandom) :
                LW_W'($urandom_range(0, 65536));
        it.ew = EW_W'($urandom);
        it.ginc = ($urandom_range(0, 7) == 0) ? GW_W'($urandom) :
                  GW_W'($urandom_range(0, 131072));
        it.gdec = ($urandom_range(0, 7) == 0) ? GW_W'($urandom) :
                  GW_W'($urandom_range(0, 131072));
        it.scale = EW_W'($urandom);
        return it;
    endfunction

    // Extremes, zero change, zero gain, clipping and out-of-range linear weight.
    task automatic test_directed();
        syn_in_t q[$];
        syn_in_t it;
        it = '{dw: 0, lw: 17'h1FFFF, ew: 20'hFFFFF, ginc: 1, gdec: 1, scale: 0};
        q.push_back(it);
        it = '{dw: 18'sh1FFFF, lw: 0, ew: 0, ginc: 18'h3FFFF, gdec: 0, scale: 20'hFFFFF};
        q.push_back(it);
        it = '{dw: -18'sd131072, lw: 65536, ew: 5, ginc: 0, gdec: 18'h3FFFF,
               scale: 20'hFFFFF};
        q.push_back(it);
        it = '{dw: 1, lw: 32768, ew: 0, ginc: 0, gdec: 0, scale: 65536};
        q.push_back(it);
        it = '{dw: 18'sd65536, lw: 17'h1FFFF, ew: 0, ginc: 131072, gdec: 131072,
               scale: 20'hFFFFF};
        q.push_back(it);
        it = '{dw: -18'sd1, lw: 17'h1FFFF, ew: 0, ginc: 131072, gdec: 131072,
               scale: 20'hFFFFF};
        q.push_back(it);
        it = '{dw: -18'sd65536, lw: 32768, ew: 0, ginc: 65536, gdec: 65536, scale: 65536};
        q.push_back(it);
        it = '{dw: 18'sd100, lw: 32767, ew: 0, ginc: 65536, gdec: 65536, scale: 65536};
        q.push_back(it);
        it = '{dw: 18'sd100, lw: 1, ew: 0, ginc: 65536, gdec: 65536, scale: 65536};
        q.push_back(it);
        it = '{dw: -18'sd100, lw: 65535, ew: 0, ginc: 65536, gdec: 65536, scale: 65536};
        q.push_back(it);
        it = '{dw: 18'sd131071, lw: 0, ew: 0, ginc: 0, gdec: 0, scale: 20'hFFFFF};
        q.push_back(it);
        it = '{dw: 18'sh2AAAA, lw: 17'h15555, ew: 20'hAAAAA, ginc: 18'h15555,
               gdec: 18'h2AAAA, scale: 20'h55555};
        q.push_back(it);
        it = '{dw: 18'sh15555, lw: 17'h0AAAA, ew: 20'h55555, ginc: 18'h2AAAA,
               gdec: 18'h15555, scale: 20'hAAAAA};
        q.push_back(it);
        send_burst(q);
    endtask

    task automatic test_random(input int n);
        syn_in_t q[$];
        repeat (n) q.push_back(random_word());
        send_burst(q);
    endtask

    // Each configuration setting gets its own random phase.
    task automatic test_config_sweep();
        for (int m = 0; m < 4; m++) begin
            wait_drained();
            write_cfg(CFG_SOFT_BOUND, m[0]);
            write_cfg(CFG_CONTRAST_MODE, m[1]);
            test_directed();
            test_random(220);
        end
    endtask

    // Receiver stalls on a mode that changes now and then.
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result checker and watchdog.
    always @(posedge aclk) begin
        syn_out_t exp_w;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                words_checked++;
                if (expected_weights.size() == 0) begin
                    $display("%0t: unexpected result lw=%0d ew=%0d upd=%0b", $time,
                             m_new_linear_weight, m_new_effective_weight, m_updated);
                    errors++;
                end else begin
                    exp_w = expected_weights.pop_front();
                    if (exp_w.nlw !== m_new_linear_weight) begin
                        $display("%0t: new_linear_weight expected %0d got %0d", $time,
                                 exp_w.nlw, m_new_linear_weight);
                        errors++;
                    end
                    if (exp_w.new_ !== m_new_effective_weight) begin
                        $display("%0t: new_effective_weight expected %0d got %0d", $time,
                                 exp_w.new_, m_new_effective_weight);
                        errors++;
                    end
                    if (exp_w.upd !== m_updated) begin
                        $display("%0t: updated expected %0b got %0b", $time,
                                 exp_w.upd, m_updated);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("Timeout with %0d results outstanding", expected_weights.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Reset configuration first, then sweep all settings.
        test_directed();
        test_random(40);
        test_config_sweep();
        wait_drained();
        $display("Covered %0d words across all soft_bound/contrast_mode settings,",
                 words_sent);
        $display("%0d results checked with random sender gaps and receiver stalls.",
                 words_checked);
        if (errors == 0 && expected_weights.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
